/* rtl/olkd_pkg.sv */
package olkd_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [1:0] req_t;
    typedef logic [1:0] status_t;
    typedef logic signed [31:0] entry_t;
    typedef logic [CNT_W-1:0] count_t;

    localparam req_t REQ_APPEND      = 2'd0;
    localparam req_t REQ_REMOVE_HEAD = 2'd1;
    localparam req_t REQ_REMOVE_TAIL = 2'd2;
    localparam req_t REQ_REMOVE_KEY  = 2'd3;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_EMPTY     = 2'd1;
    localparam status_t STATUS_NOT_FOUND = 2'd2;
    localparam status_t STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic capture;
        logic shift;
        logic write;
    } cell_ctl_t;

endpackage

/* rtl/ordered_list_with_key_delete_top.sv */
// Bounded list of signed 32-bit values kept in insertion order, held in a row of cells.
// The input channel carries req_type and value; the output channel returns status and
// entry_count. Each channel moves a transfer when its valid is high and its stall is low.
// When a request is taken, every cell compares its entry with the key and records a match.
// When the request commits, the first match travels along the row, the cells behind it
// take their neighbour's entry, and the result is written into the output register.
// The commit waits while the output register still holds an unaccepted result, and the
// block takes no new request until the compare-then-shift pass has committed the last one.
// A new request is taken while the previous result still waits in the output register;
// if the receiver keeps stalling, the second request holds until the register frees,
// and in_stall stays high meanwhile.
// Reset empties the list, clears out_valid and leaves in_stall low; the entries are not
// cleared, as only entries below the count are ever read.
module ordered_list_with_key_delete_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  olkd_pkg::req_t          req_type,
    input  olkd_pkg::entry_t        value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output olkd_pkg::status_t       status,
    output olkd_pkg::count_t        entry_count
);
    import olkd_pkg::*;

    localparam logic STATE_IDLE   = 1'b0;
    localparam logic STATE_COMMIT = 1'b1;

    logic      state_reg;
    logic      state_next;
    req_t      req_reg;
    entry_t    value_reg;
    count_t    len_reg;
    count_t    len_next;
    logic      out_valid_reg;
    status_t   status_reg;
    status_t   status_next;
    count_t    count_reg;

    logic      accept;
    logic      commit;
    logic      out_free;
    logic      any_hit;

    cell_ctl_t ctl      [DEPTH];
    logic      occupied [DEPTH];
    entry_t    entries  [DEPTH];
    logic      hits     [DEPTH+1];

    assign in_stall    = (state_reg != STATE_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign commit      = (state_reg == STATE_COMMIT) && out_free;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;

    assign hits[0] = commit && (req_reg == REQ_REMOVE_HEAD);
    assign any_hit = hits[DEPTH];

    always_comb
    begin
        status_next = STATUS_OK;
        len_next    = len_reg;
        if (req_reg == REQ_APPEND)
        begin
            if (len_reg >= CNT_W'(DEPTH))
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                len_next = len_reg + CNT_W'(1);
            end
        end
        else if (len_reg == '0)
        begin
            status_next = STATUS_EMPTY;
        end
        else if ((req_reg == REQ_REMOVE_KEY) && !any_hit)
        begin
            status_next = STATUS_NOT_FOUND;
        end
        else
        begin
            len_next = len_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            STATE_IDLE:
            begin
                if (accept)
                begin
                    state_next = STATE_COMMIT;
                end
            end
            STATE_COMMIT:
            begin
                if (commit)
                begin
                    state_next = STATE_IDLE;
                end
            end
            default:
            begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                len_reg       <= len_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            value_reg <= value;
        end
        if (commit)
        begin
            status_reg <= status_next;
            count_reg  <= len_next;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign occupied[i]  = (CNT_W'(i) < len_reg);
        assign ctl[i].capture = accept;
        assign ctl[i].shift   = commit && ((req_reg == REQ_REMOVE_HEAD)
                                || (req_reg == REQ_REMOVE_KEY));
        assign ctl[i].write   = commit && (req_reg == REQ_APPEND)
                                && (CNT_W'(i) == len_reg);

        olkd_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl[i]),
            .occupied     (occupied[i]),
            .key          (value),
            .append_value (value_reg),
            .next_entry   ((i == DEPTH - 1) ? entries[i] : entries[(i + 1) % DEPTH]),
            .hit_in       (hits[i]),
            .hit_out      (hits[i+1]),
            .entry        (entries[i])
        );
    end

endmodule

/* rtl/olkd_cell.sv */
module olkd_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  olkd_pkg::cell_ctl_t ctl,
    input  logic              occupied,
    input  olkd_pkg::entry_t  key,
    input  olkd_pkg::entry_t  append_value,
    input  olkd_pkg::entry_t  next_entry,
    input  logic              hit_in,
    output logic              hit_out,
    output olkd_pkg::entry_t  entry
);
    import olkd_pkg::*;

    entry_t entry_reg;
    logic   hit_reg;

    // The hit travels towards the tail, so every cell at or behind the first match moves.
    assign hit_out = hit_in | hit_reg;
    assign entry   = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            hit_reg <= occupied && (entry_reg == key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            entry_reg <= append_value;
        end
        else if (ctl.shift && hit_out)
        begin
            entry_reg <= next_entry;
        end
    end

endmodule
